// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and synchronous reset
`define SWM_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define SWM_ASSERT(label, prop, msg) \
   `SWM_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Widths, reset values and the link types between sorted-window cells.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int MEDIAN_W       = 33;
   localparam int CSR_W          = 7;
   localparam int WINDOW_MAX_DEF = 64;

   localparam logic [CSR_W-1:0] WINDOW_SIZE_RST = CSR_W'(3);

   // what a cell tells its left neighbor
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                above_old;   // value above the leaving sample, or empty
      logic                above_new;   // value above the arriving sample
   } cell_fwd_type;

   // what a cell tells its right neighbor: its entry after removal
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                gt;          // entry above the arriving sample, or empty
   } cell_bwd_type;

   // broadcast to every cell for one item
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] oldest;
      logic                remove;
      logic                load;
   } swm_bcast_type;

   localparam cell_fwd_type FWD_EDGE = '{value: '0, above_old: 1'b1, above_new: 1'b1};
   localparam cell_bwd_type BWD_EDGE = '{value: '0, gt: 1'b0};

endpackage

// File: src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One entry of the sorted window: drops the leaving sample and inserts the
// arriving one, using only its two neighbors and the broadcast item.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
#(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic                clock,
   input  swm_bcast_type       bcast,
   input  logic [CW-1:0]       fill,
   input  logic [CW-1:0]       kept_len,
   input  cell_fwd_type        right_in,
   input  cell_bwd_type        left_in,
   output cell_fwd_type        left_out,
   output cell_bwd_type        right_out,
   output logic [SAMPLE_W-1:0] value
);

   localparam logic [CW-1:0] POS = CW'(IDX);

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;
   logic [SAMPLE_W-1:0] kept;
   logic                shift_left;
   logic                kept_gt;

   // local compares against the leaving and arriving samples
   always_comb begin
      left_out.value     = value_ff;
      left_out.above_old = !(fill > POS) || ($signed(value_ff) > $signed(bcast.oldest));
      left_out.above_new = $signed(value_ff) > $signed(bcast.sample);
   end

   // removal: entries past the leaving sample move one place left
   always_comb begin
      shift_left      = bcast.remove && right_in.above_old;
      kept            = shift_left ? right_in.value : value_ff;
      kept_gt         = !(kept_len > POS) ||
                        (shift_left ? right_in.above_new : left_out.above_new);
      right_out.value = kept;
      right_out.gt    = kept_gt;
   end

   // insertion: entries above the sample move one place right
   always_comb begin
      if (left_in.gt) begin
         value_in = left_in.value;
      end else if (kept_gt) begin
         value_in = bcast.sample;
      end else begin
         value_in = kept;
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.load) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: src/swm_ring.sv
// ----------------------------------------------------------------------------
// swm_ring
// Arrival-order sample store; the read port prefetches the slot of the
// oldest sample, with write-through when both ports hit the same slot.
// ----------------------------------------------------------------------------
module swm_ring
   import swm_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read with same-slot forwarding
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sliding_window_median.sv
// Timing: cells update at the accepting edge, and the median register loads from them once the
// output is free.
// Throughput: one sample per cycle; every cell compares and shifts in the cycle of acceptance.
// The only stall is a held result together with a median still waiting to leave.
// Reset (synchronous, active high): window size 3, window empty, no result pending.
// Window contents and the arrival ring are not cleared; fill count decides what is used.
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median of the last K signed samples, kept in a sorted row of cells,
// given as twice the median (one fractional bit).
// ----------------------------------------------------------------------------
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_start_req,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   input  logic                       csr_wr_en,
   input  logic [CSR_W-1:0]           csr_wr_data
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [CSR_W-1:0]    ws_ff, ws_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic                calc_ff, calc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0] median_ff, median_in;

   logic [CW-1:0]       win_k;
   logic [CW-1:0]       fill_eff;
   logic [IW-1:0]       pos_eff;
   logic [CW-1:0]       kept_len;
   logic [CW-1:0]       new_fill;
   logic [CW-1:0]       pos_plus;
   logic [IW-1:0]       pos_next;
   logic                full;
   logic                accept;
   logic                out_free;
   logic [SAMPLE_W-1:0] oldest;
   swm_bcast_type       bcast;

   logic [CW-1:0]       half;
   logic [IW-1:0]       idx_hi, idx_lo;
   logic [SAMPLE_W-1:0] mid_hi, mid_lo;

   cell_fwd_type        fwd [WINDOW_MAX];
   cell_bwd_type        bwd [WINDOW_MAX];
   logic [SAMPLE_W-1:0] cell_value [WINDOW_MAX];

   // effective window size, clamped to 1..WINDOW_MAX
   always_comb begin
      if (ws_ff == '0) begin
         win_k = CW'(1);
      end else if (32'(ws_ff) > WINDOW_MAX) begin
         win_k = CW'(WINDOW_MAX);
      end else begin
         win_k = CW'(ws_ff);
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !(calc_ff && !out_free);
   assign accept    = req_valid && req_ready;

   // window bookkeeping for the arriving item
   always_comb begin
      fill_eff = req_start_req ? '0 : fill_ff;
      pos_eff  = req_start_req ? '0 : pos_ff;
      full     = (fill_eff == win_k);
      kept_len = full ? fill_eff - CW'(1) : fill_eff;
      new_fill = kept_len + CW'(1);
      pos_plus = CW'(pos_eff) + CW'(1);
      pos_next = (pos_plus >= win_k) ? '0 : pos_plus[IW-1:0];
   end

   // control registers next state
   always_comb begin
      ws_in   = ws_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      if (csr_wr_en) begin
         ws_in   = csr_wr_data;
         fill_in = '0;
         pos_in  = '0;
      end else if (accept) begin
         fill_in = new_fill;
         pos_in  = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= WINDOW_SIZE_RST;
         fill_ff <= '0;
         pos_ff  <= '0;
      end else begin
         ws_ff   <= ws_in;
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   // arrival ring, read port follows the oldest slot
   swm_ring #(
      .DEPTH (WINDOW_MAX),
      .AW    (IW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_eff),
      .wr_data (req_sample),
      .rd_addr (pos_in),
      .rd_data (oldest)
   );

   always_comb begin
      bcast.sample = req_sample;
      bcast.oldest = oldest;
      bcast.remove = full;
      bcast.load   = accept;
   end

   // sorted row of cells
   for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      cell_fwd_type rin;
      cell_bwd_type lin;

      if (gi == WINDOW_MAX - 1) begin : g_right
         assign rin = FWD_EDGE;
      end else begin : g_right
         assign rin = fwd[gi+1];
      end

      if (gi == 0) begin : g_left
         assign lin = BWD_EDGE;
      end else begin : g_left
         assign lin = bwd[gi-1];
      end

      swm_cell #(
         .CW  (CW),
         .IDX (gi)
      ) u_cell (
         .clock     (clock),
         .bcast     (bcast),
         .fill      (fill_eff),
         .kept_len  (kept_len),
         .right_in  (rin),
         .left_in   (lin),
         .left_out  (fwd[gi]),
         .right_out (bwd[gi]),
         .value     (cell_value[gi])
      );
   end

   // median stage: pick the middle entries and add
   always_comb begin
      half   = win_k >> 1;
      idx_hi = half[IW-1:0];
      idx_lo = win_k[0] ? idx_hi : idx_hi - IW'(1);
      mid_hi = cell_value[idx_hi];
      mid_lo = cell_value[idx_lo];
   end

   always_comb begin
      calc_in      = calc_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (calc_ff && out_free) begin
         rsp_valid_in = 1'b1;
         median_in    = {mid_hi[SAMPLE_W-1], mid_hi} + {mid_lo[SAMPLE_W-1], mid_lo};
         calc_in      = 1'b0;
      end
      if (accept) begin
         calc_in = (new_fill == win_k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         calc_ff      <= calc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

endmodule

// File: src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the result channel and the input stall rule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swm_checker
   import swm_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [MEDIAN_W-1:0] rsp_median_doubled
);

   logic req_take;
   logic rsp_held;

   assign req_take = req_valid && req_ready;
   assign rsp_held = rsp_valid && !rsp_ready;

   // a held result stays until taken
   `SWM_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid, "held result dropped")

   // a held result keeps its value
   `SWM_ASSERT(a_rsp_stable, rsp_held |=> $stable(rsp_median_doubled), "held result changed")

   // a new result rises the edge after its item was accepted
   `SWM_ASSERT(a_rsp_after_req, $rose(rsp_valid) |-> $past(req_take, 2), "result with no item")

   // input stalls only behind a blocked result
   `SWM_ASSERT(a_stall_cause, !req_ready |-> rsp_held, "input stalled with output free")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
